/* hdl/tgst_pkg.sv */
// Shared constants, register index codes and the BCD helper for the two-gate speed trap.
`timescale 1ns / 1ps

package tgst_pkg;

   localparam int STAMP_WIDTH_DEFAULT = 32;

   localparam int NUM_WIDTH       = 24;
   localparam int SPEED_WIDTH     = 7;
   localparam int TICKS_WIDTH     = 16;
   localparam int DISPLAY_WIDTH   = 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = NUM_WIDTH;

   localparam logic [NUM_WIDTH-1:0]   NUMERATOR_RESET = 24'd36000;
   localparam logic [SPEED_WIDTH-1:0] LIMIT_RESET     = 7'd20;
   localparam logic [TICKS_WIDTH-1:0] TIMEOUT_RESET   = 16'd15000;
   localparam logic [TICKS_WIDTH-1:0] HOLDOFF_RESET   = 16'd5000;
   localparam logic [TICKS_WIDTH-1:0] ALERT_RESET     = 16'd10000;

   localparam logic [SPEED_WIDTH-1:0] SPEED_MAX = 7'd99;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SPEED_NUMERATOR = 3'd0,
      CSR_SPEED_LIMIT     = 3'd1,
      CSR_WAIT_TIMEOUT    = 3'd2,
      CSR_HOLDOFF         = 3'd3,
      CSR_ALERT_TICKS     = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_WAIT_A = 2'd1,
      PH_WAIT_B = 2'd2,
      PH_HOLD   = 2'd3
   } phase_type;

   // two BCD digits of a value 0..99; tens by reciprocal multiply, exact below 179
   function automatic logic [DISPLAY_WIDTH-1:0] to_bcd(input logic [SPEED_WIDTH-1:0] v);
      logic [13:0]            prod;
      logic [3:0]             tens;
      logic [SPEED_WIDTH-1:0] rest;
      prod = 14'(v) * 14'd103;
      tens = prod[13:10];
      rest = v - SPEED_WIDTH'(SPEED_WIDTH'(tens) * 7'd10);
      return {tens, rest[3:0]};
   endfunction

endpackage

/* hdl/two_gate_speed_trap.sv */
// Two-gate speed trap: tick handling, bit-serial speed divider and result register.
`timescale 1ns / 1ps

// Usage
//  - req_* carries one tick per transaction: the levels of gate A and gate B.
//  - rsp_* returns one transaction per tick: held display byte (BCD speed, 0x00
//    after a timeout), alert level, reading-done and timeout pulses.
//  - csr_* writes the five setup registers (numerator, limit, wait timeout,
//    hold-off, alert length) by index; write only while no tick is in flight.
// Flow
//  - An ordinary tick goes from ST_ACCEPT to ST_EMIT, which loads rsp_valid.
//  - A tick that completes a reading runs the restoring divider, one numerator
//    bit per cycle, then round/clamp (ST_FIN) and BCD (ST_BCD) before ST_EMIT.
//  - Ticks are processed one at a time; the next tick is accepted once the
//    current one has reached the result register.
// Reset clears control state, loads the register defaults; held display is 0x00.
// A stalled receiver holds the result; one further tick may be accepted and
// processed, then waits until the result register frees.
module two_gate_speed_trap #(
   parameter int STAMP_WIDTH = tgst_pkg::STAMP_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_gate_a_level,
   input  logic                                 req_gate_b_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tgst_pkg::DISPLAY_WIDTH-1:0]   rsp_display_code,
   output logic                                 rsp_alert_on,
   output logic                                 rsp_reading_done,
   output logic                                 rsp_wait_expired,
   input  logic                                 csr_write_enable,
   input  logic [tgst_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tgst_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int NW = tgst_pkg::NUM_WIDTH;
   localparam int SW = tgst_pkg::SPEED_WIDTH;
   localparam int TW = tgst_pkg::TICKS_WIDTH;
   localparam int DW = tgst_pkg::DISPLAY_WIDTH;
   localparam int CNT_WIDTH = $clog2(NW);

   typedef enum logic [2:0] {
      ST_ACCEPT,
      ST_DIV,
      ST_FIN,
      ST_BCD,
      ST_EMIT
   } st_type;

   // control and state
   st_type              st_ff, st_in;
   tgst_pkg::phase_type phase_ff, phase_in;
   logic [1:0]             prev_ff, prev_in;
   logic [STAMP_WIDTH-1:0] tick_ff, tick_in;
   logic [STAMP_WIDTH-1:0] first_stamp_ff, first_stamp_in;
   logic [TW-1:0]          timer_ff, timer_in;
   logic [STAMP_WIDTH-1:0] alert_start_ff, alert_start_in;
   logic [DW-1:0]          display_ff, display_in;
   logic                   alert_ff, alert_in;
   logic                   done_ff, done_in;
   logic                   tmo_ff, tmo_in;

   // setup registers
   logic [NW-1:0] num_ff, num_in;
   logic [SW-1:0] limit_ff, limit_in;
   logic [TW-1:0] wait_timeout_ff, wait_timeout_in;
   logic [TW-1:0] holdoff_ff, holdoff_in;
   logic [TW-1:0] alert_ticks_ff, alert_ticks_in;

   // divider
   logic [STAMP_WIDTH-1:0] div_ff, div_in;
   logic [STAMP_WIDTH-1:0] rem_ff, rem_in;
   logic [NW-1:0]          quo_ff, quo_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [SW-1:0]          spd_ff, spd_in;
   logic                   fast_ff, fast_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_display_ff, rsp_display_in;
   logic          rsp_alert_ff, rsp_alert_in;
   logic          rsp_done_ff, rsp_done_in;
   logic          rsp_tmo_ff, rsp_tmo_in;

   // combinational temporaries
   logic [1:0]             lv;
   logic                   changed;
   logic                   ev_a, ev_b, finish;
   logic [STAMP_WIDTH-1:0] tick_n;
   logic [STAMP_WIDTH-1:0] alert_elapsed;
   logic [TW-1:0]          timer_inc;
   logic [STAMP_WIDTH:0]   rem_sh, diff;
   logic                   take;
   logic                   round_up, over_max, over_limit;

   assign req_ready         = (st_ff == ST_ACCEPT);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_display_code  = rsp_display_ff;
   assign rsp_alert_on      = rsp_alert_ff;
   assign rsp_reading_done  = rsp_done_ff;
   assign rsp_wait_expired  = rsp_tmo_ff;

   always_comb begin
      st_in           = st_ff;
      phase_in        = phase_ff;
      prev_in         = prev_ff;
      tick_in         = tick_ff;
      first_stamp_in  = first_stamp_ff;
      timer_in        = timer_ff;
      alert_start_in  = alert_start_ff;
      display_in      = display_ff;
      alert_in        = alert_ff;
      done_in         = done_ff;
      tmo_in          = tmo_ff;
      num_in          = num_ff;
      limit_in        = limit_ff;
      wait_timeout_in = wait_timeout_ff;
      holdoff_in      = holdoff_ff;
      alert_ticks_in  = alert_ticks_ff;
      div_in          = div_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      cnt_in          = cnt_ff;
      spd_in          = spd_ff;
      fast_in         = fast_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_display_in  = rsp_display_ff;
      rsp_alert_in    = rsp_alert_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_tmo_in      = rsp_tmo_ff;

      lv            = {req_gate_b_level, req_gate_a_level};
      changed       = (lv != prev_ff);
      ev_a          = changed && req_gate_a_level &&
                      (phase_ff == tgst_pkg::PH_IDLE || phase_ff == tgst_pkg::PH_WAIT_A);
      ev_b          = !ev_a && changed && req_gate_b_level &&
                      (phase_ff == tgst_pkg::PH_IDLE || phase_ff == tgst_pkg::PH_WAIT_B);
      finish        = (ev_a && phase_ff == tgst_pkg::PH_WAIT_A) ||
                      (ev_b && phase_ff == tgst_pkg::PH_WAIT_B);
      tick_n        = tick_ff + 1'b1;
      alert_elapsed = tick_n - alert_start_ff;
      timer_inc     = timer_ff + 1'b1;

      rem_sh = {rem_ff, quo_ff[NW-1]};
      diff   = rem_sh - {1'b0, div_ff};
      take   = !diff[STAMP_WIDTH];

      round_up   = ({rem_ff, 1'b0} >= {1'b0, div_ff});
      over_max   = (quo_ff > NW'(tgst_pkg::SPEED_MAX)) ||
                   (quo_ff == NW'(tgst_pkg::SPEED_MAX) && rem_ff != '0);
      over_limit = (quo_ff > NW'(limit_ff)) ||
                   (quo_ff == NW'(limit_ff) && rem_ff != '0);

      if (csr_write_enable) begin
         unique case (csr_index)
            tgst_pkg::CSR_SPEED_NUMERATOR: num_in          = csr_write_data[NW-1:0];
            tgst_pkg::CSR_SPEED_LIMIT:     limit_in        = csr_write_data[SW-1:0];
            tgst_pkg::CSR_WAIT_TIMEOUT:    wait_timeout_in = csr_write_data[TW-1:0];
            tgst_pkg::CSR_HOLDOFF:         holdoff_in      = csr_write_data[TW-1:0];
            tgst_pkg::CSR_ALERT_TICKS:     alert_ticks_in  = csr_write_data[TW-1:0];
            default: ;
         endcase
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (st_ff)
         ST_ACCEPT: begin
            if (req_valid) begin
               tick_in = tick_n;
               prev_in = lv;
               done_in = 1'b0;
               tmo_in  = 1'b0;
               st_in   = ST_EMIT;
               if ((ev_a || ev_b) && phase_ff == tgst_pkg::PH_IDLE) begin
                  first_stamp_in = tick_n;
                  phase_in       = ev_a ? tgst_pkg::PH_WAIT_B : tgst_pkg::PH_WAIT_A;
                  timer_in       = '0;
               end else if (finish) begin
                  // second gate: start the divide, display/alert land in ST_BCD
                  phase_in = tgst_pkg::PH_HOLD;
                  timer_in = '0;
                  done_in  = 1'b1;
                  div_in   = tick_n - first_stamp_ff;
                  quo_in   = num_ff;
                  rem_in   = '0;
                  cnt_in   = CNT_WIDTH'(NW - 1);
                  st_in    = ST_DIV;
               end else if (phase_ff == tgst_pkg::PH_WAIT_A ||
                            phase_ff == tgst_pkg::PH_WAIT_B) begin
                  if (timer_inc >= wait_timeout_ff) begin
                     display_in = '0;
                     tmo_in     = 1'b1;
                     phase_in   = tgst_pkg::PH_IDLE;
                     timer_in   = '0;
                  end else begin
                     timer_in = timer_inc;
                  end
               end else if (phase_ff == tgst_pkg::PH_HOLD) begin
                  if (timer_inc >= holdoff_ff) begin
                     phase_in = tgst_pkg::PH_IDLE;
                     timer_in = '0;
                  end else begin
                     timer_in = timer_inc;
                  end
               end
               // expiry against the old start; a fast reading re-arms it later
               if (alert_ff && alert_elapsed > STAMP_WIDTH'(alert_ticks_ff)) begin
                  alert_in = 1'b0;
               end
            end
         end
         ST_DIV: begin
            rem_in = take ? diff[STAMP_WIDTH-1:0] : rem_sh[STAMP_WIDTH-1:0];
            quo_in = {quo_ff[NW-2:0], take};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               st_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (div_ff == '0) begin
               spd_in  = tgst_pkg::SPEED_MAX;
               fast_in = 1'b1;
            end else begin
               spd_in  = over_max ? tgst_pkg::SPEED_MAX : quo_ff[SW-1:0] + SW'(round_up);
               fast_in = over_limit;
            end
            st_in = ST_BCD;
         end
         ST_BCD: begin
            display_in = tgst_pkg::to_bcd(spd_ff);
            if (fast_ff) begin
               alert_in       = 1'b1;
               alert_start_in = tick_ff;
            end
            st_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_display_in = display_ff;
               rsp_alert_in   = alert_ff;
               rsp_done_in    = done_ff;
               rsp_tmo_in     = tmo_ff;
               st_in          = ST_ACCEPT;
            end
         end
         default: st_in = ST_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff           <= ST_ACCEPT;
         phase_ff        <= tgst_pkg::PH_IDLE;
         prev_ff         <= '0;
         tick_ff         <= '0;
         first_stamp_ff  <= '0;
         timer_ff        <= '0;
         alert_start_ff  <= '0;
         display_ff      <= '0;
         alert_ff        <= 1'b0;
         done_ff         <= 1'b0;
         tmo_ff          <= 1'b0;
         num_ff          <= tgst_pkg::NUMERATOR_RESET;
         limit_ff        <= tgst_pkg::LIMIT_RESET;
         wait_timeout_ff <= tgst_pkg::TIMEOUT_RESET;
         holdoff_ff      <= tgst_pkg::HOLDOFF_RESET;
         alert_ticks_ff  <= tgst_pkg::ALERT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         st_ff           <= st_in;
         phase_ff        <= phase_in;
         prev_ff         <= prev_in;
         tick_ff         <= tick_in;
         first_stamp_ff  <= first_stamp_in;
         timer_ff        <= timer_in;
         alert_start_ff  <= alert_start_in;
         display_ff      <= display_in;
         alert_ff        <= alert_in;
         done_ff         <= done_in;
         tmo_ff          <= tmo_in;
         num_ff          <= num_in;
         limit_ff        <= limit_in;
         wait_timeout_ff <= wait_timeout_in;
         holdoff_ff      <= holdoff_in;
         alert_ticks_ff  <= alert_ticks_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      div_ff         <= div_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      cnt_ff         <= cnt_in;
      spd_ff         <= spd_in;
      fast_ff        <= fast_in;
      rsp_display_ff <= rsp_display_in;
      rsp_alert_ff   <= rsp_alert_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_tmo_ff     <= rsp_tmo_in;
   end

`ifndef SYNTHESIS
   a_pulses_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_reading_done && rsp_wait_expired))
      else $error("reading and timeout flagged in one transaction");

   a_timeout_blanks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wait_expired |-> rsp_display_code == '0)
      else $error("timeout transaction with non-blank display");

   a_reading_bcd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reading_done |->
         rsp_display_code[3:0] <= 4'd9 && rsp_display_code[7:4] <= 4'd9)
      else $error("reading display not valid BCD");

   a_reading_holds: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_BCD |-> phase_ff == tgst_pkg::PH_HOLD && done_ff)
      else $error("speed finishing outside hold-off");
`endif

endmodule
